[rtl/multi_pattern_byte_matcher_core_macros.svh]
// Assertion helpers shared by the matcher modules.
`ifndef MULTI_PATTERN_BYTE_MATCHER_CORE_MACROS_SVH
`define MULTI_PATTERN_BYTE_MATCHER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPBM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matcher check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MPBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matcher check failed one cycle later");

`endif

[rtl/mpbm_pkg.sv]
`default_nettype none
package mpbm_pkg;

   localparam int REG_PATTERNS        = 4;
   localparam int DEF_NUM_PATTERNS    = 4;
   localparam int DEF_MAX_PATTERN_LEN = 8;
   localparam int BYTE_W              = 8;
   localparam int WORD_W              = 64;
   localparam int LEN_W               = 4;
   localparam int COUNT_W             = 32;
   localparam int CSR_INDEX_W         = 3;
   localparam int REQ_TDATA_W         = 8;
   localparam int RSP_TDATA_W         = 72;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_BASE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN_BASE  = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

   typedef struct packed {
      logic                    valid;
      logic                    restart;
      logic [BYTE_W-1:0]       text_byte;
      logic [REG_PATTERNS-1:0] hit_mask;
   } stage_type;

endpackage
`default_nettype wire

[rtl/multi_pattern_byte_matcher_core.sv]
// A byte accepted at one clock edge is registered in the first cell, then in each further
// cell and last in the tally register, whose output carries the result for that byte.
// Throughput: one byte per cycle, set by the single-stage compare in each cell.
// A stalled result stalls the whole chain; req_tready follows rsp_tready then.
// Reset is synchronous, holds req_tready low and clears the pattern registers, progress,
// counters and valids.
`default_nettype none
module multi_pattern_byte_matcher_core
   import mpbm_pkg::*;
#(
   parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
   parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // text_byte[7:0]
   input  wire logic                   req_tuser,  // restart
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // hit_mask[3:0], hit_total[35:4],
                                                   // byte_index[67:36], zero[71:68]
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_wdata
);

   localparam int NUM_CELLS = (NUM_PATTERNS < REG_PATTERNS) ? NUM_PATTERNS : REG_PATTERNS;

   logic                    advance;
   stage_type               chain [NUM_CELLS+1];
   logic [REG_PATTERNS-1:0] hit_mask;
   logic [COUNT_W-1:0]      hit_total;
   logic [COUNT_W-1:0]      byte_index;

   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance & ~reset;

   always_comb begin
      chain[0]           = '0;
      chain[0].valid     = req_tvalid;
      chain[0].restart   = req_tuser;
      chain[0].text_byte = req_tdata[BYTE_W-1:0];
   end

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      mpbm_cell #(
         .CELL_INDEX      (g),
         .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .csr_wen   (csr_wen),
         .csr_index (csr_index),
         .csr_wdata (csr_wdata),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   mpbm_tally u_tally (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .stage_in       (chain[NUM_CELLS]),
      .rsp_valid      (rsp_tvalid),
      .rsp_hit_mask   (hit_mask),
      .rsp_hit_total  (hit_total),
      .rsp_byte_index (byte_index)
   );

   assign rsp_tdata = {4'b0000, byte_index, hit_total, hit_mask};

endmodule
`default_nettype wire

[rtl/mpbm_cell.sv]
`default_nettype none
`include "multi_pattern_byte_matcher_core_macros.svh"
module mpbm_cell
   import mpbm_pkg::*;
#(
   parameter int CELL_INDEX      = 0,
   parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_wdata,
   input  wire stage_type              stage_in,
   output stage_type                   stage_out
);

   localparam int PROG_W = $clog2(MAX_PATTERN_LEN + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_LEN);
   localparam logic [CSR_INDEX_W-1:0] WORD_IDX =
      CSR_PATTERN_WORD_BASE + CSR_INDEX_W'(CELL_INDEX);
   localparam logic [CSR_INDEX_W-1:0] LEN_IDX =
      CSR_PATTERN_LEN_BASE + CSR_INDEX_W'(CELL_INDEX);

   logic [WORD_W-1:0] word_ff, word_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [PROG_W-1:0] prog_ff, prog_in;
   stage_type         stage_ff, stage_in_next;

   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  prog_cur;
   logic [LEN_W-1:0]  prog_inc;
   logic [LEN_W-1:0]  prog_next;
   logic [BYTE_W-1:0] pat_byte;
   logic              hit;

   always_comb begin
      len_eff  = (len_ff > MAX_LEN) ? MAX_LEN : len_ff;
      prog_cur = stage_in.restart ? '0 : LEN_W'(prog_ff);
      if (prog_cur >= len_eff) begin
         prog_cur = '0;
      end
      pat_byte  = word_ff[{prog_cur[2:0], 3'b000} +: BYTE_W];
      prog_inc  = prog_cur + LEN_W'(1);
      hit       = 1'b0;
      prog_next = '0;
      if (len_eff != '0 && pat_byte == stage_in.text_byte) begin
         if (prog_inc == len_eff) begin
            hit = 1'b1;
         end else begin
            prog_next = prog_inc;
         end
      end
   end

   always_comb begin
      word_in       = word_ff;
      len_in        = len_ff;
      prog_in       = prog_ff;
      stage_in_next = stage_ff;
      if (csr_wen && csr_index == WORD_IDX) begin
         word_in = csr_wdata;
      end
      if (csr_wen && csr_index == LEN_IDX) begin
         len_in = csr_wdata[LEN_W-1:0];
      end
      if (advance) begin
         stage_in_next = stage_in;
         if (stage_in.valid) begin
            prog_in = PROG_W'(prog_next);
            stage_in_next.hit_mask[CELL_INDEX] = hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         len_ff   <= '0;
         prog_ff  <= '0;
         stage_ff <= '0;
      end else begin
         word_ff  <= word_in;
         len_ff   <= len_in;
         prog_ff  <= prog_in;
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

   `MPBM_ASSERT_NOW(cell_prog_bound, clock, reset, 1'b1, LEN_W'(prog_ff) < MAX_LEN)
   `MPBM_ASSERT_NEXT(cell_disabled_idle, clock, reset,
      advance && stage_in.valid && len_ff == '0, prog_ff == '0)
   `MPBM_ASSERT_NOW(cell_hit_valid, clock, reset, stage_ff.hit_mask[CELL_INDEX], stage_ff.valid)

endmodule
`default_nettype wire

[rtl/mpbm_tally.sv]
`default_nettype none
`include "multi_pattern_byte_matcher_core_macros.svh"
module mpbm_tally
   import mpbm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire stage_type               stage_in,
   output logic                         rsp_valid,
   output logic [REG_PATTERNS-1:0]      rsp_hit_mask,
   output logic [COUNT_W-1:0]           rsp_hit_total,
   output logic [COUNT_W-1:0]           rsp_byte_index
);

   localparam int CNT_W = $clog2(REG_PATTERNS + 1);

   logic [COUNT_W-1:0]      hits_ff, hits_in;
   logic [COUNT_W-1:0]      pos_ff, pos_in;
   logic                    valid_ff, valid_in;
   logic [REG_PATTERNS-1:0] mask_ff, mask_in;
   logic [COUNT_W-1:0]      total_ff, total_in;
   logic [COUNT_W-1:0]      index_ff, index_in;

   logic [CNT_W-1:0]   hit_count;
   logic [COUNT_W-1:0] hits_base;
   logic [COUNT_W-1:0] pos_base;
   logic [COUNT_W-1:0] hits_new;

   always_comb begin
      hit_count = '0;
      for (int k = 0; k < REG_PATTERNS; k++) begin
         hit_count = hit_count + CNT_W'(stage_in.hit_mask[k]);
      end
      hits_base = stage_in.restart ? '0 : hits_ff;
      pos_base  = stage_in.restart ? '0 : pos_ff;
      if ((COUNT_SAT - hits_base) < COUNT_W'(hit_count)) begin
         hits_new = COUNT_SAT;
      end else begin
         hits_new = hits_base + COUNT_W'(hit_count);
      end
   end

   always_comb begin
      hits_in  = hits_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      mask_in  = mask_ff;
      total_in = total_ff;
      index_in = index_ff;
      if (advance) begin
         valid_in = stage_in.valid;
         if (stage_in.valid) begin
            mask_in  = stage_in.hit_mask;
            total_in = hits_new;
            index_in = pos_base;
            hits_in  = hits_new;
            pos_in   = (pos_base == COUNT_SAT) ? COUNT_SAT : pos_base + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff  <= '0;
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         hits_ff  <= hits_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff  <= mask_in;
      total_ff <= total_in;
      index_ff <= index_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_hit_mask   = mask_ff;
   assign rsp_hit_total  = total_ff;
   assign rsp_byte_index = index_ff;

   `MPBM_ASSERT_NEXT(tally_total_monotonic, clock, reset,
      advance && stage_in.valid && !stage_in.restart, hits_ff >= $past(hits_ff))
   `MPBM_ASSERT_NEXT(tally_restart_index, clock, reset,
      advance && stage_in.valid && stage_in.restart, pos_ff == 1 && index_ff == '0)
   `MPBM_ASSERT_NEXT(tally_no_hit_hold, clock, reset,
      advance && stage_in.valid && !stage_in.restart && stage_in.hit_mask == '0,
      hits_ff == $past(hits_ff))

endmodule
`default_nettype wire
